>>> hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the prediction reconcile table
// Field widths, mode and verdict codes, configuration register indexes, the
// command and link records that run along the cell row, and helpers.
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int MODE_W     = 2;
    localparam int TICK_W     = 32;
    localparam int HASH_W     = 64;
    localparam int MAG_W      = 32;
    localparam int WINDOW_W   = 16;
    localparam int COUNT_W    = 32;
    localparam int VERDICT_W  = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_PREDICT = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_COMPARE = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CLEAR   = MODE_W'(2);

    localparam logic [VERDICT_W-1:0] VERDICT_MATCHED     = VERDICT_W'(0);
    localparam logic [VERDICT_W-1:0] VERDICT_CORRECT     = VERDICT_W'(1);
    localparam logic [VERDICT_W-1:0] VERDICT_RESYNC      = VERDICT_W'(2);
    localparam logic [VERDICT_W-1:0] VERDICT_UNPREDICTED = VERDICT_W'(3);

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_TOLERANCE = CFG_INDEX_W'(1);

    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = WINDOW_W'(32);
    localparam logic [MAG_W-1:0]    TOLERANCE_RESET = MAG_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } prt_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_OVERWRITE,
        OP_INSERT,
        OP_CLEAR
    } prt_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        prt_op_t             op;
        logic                latch;
        logic [TICK_W-1:0]   tick;
        logic [HASH_W-1:0]   hash;
        logic [TICK_W-1:0]   floor_tick;
    } prt_cmd_t;

    // Passed from each cell to its right-hand neighbor.
    typedef struct packed {
        logic                found;
        logic [HASH_W-1:0]   hash;
        logic                free_seen;
    } prt_link_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
        logic [COUNT_W-1:0] result;
        result = (value == {COUNT_W{1'b1}}) ? value : value + COUNT_W'(1);
        return result;
    endfunction

endpackage

>>> hdl/prt_item_if.sv
// ----------------------------------------------------------------------------
// prt_item_if: input item channel
// Valid/ready channel carrying one predict, compare or clear item.
// ----------------------------------------------------------------------------
interface prt_item_if;
    logic                          valid;
    logic                          ready;
    logic [prt_pkg::MODE_W-1:0]    mode;
    logic [prt_pkg::TICK_W-1:0]    tick_number;
    logic [prt_pkg::HASH_W-1:0]    hash_value;
    logic [prt_pkg::MAG_W-1:0]     error_magnitude;

    modport source (output valid, mode, tick_number, hash_value, error_magnitude,
                    input ready);
    modport sink   (input valid, mode, tick_number, hash_value, error_magnitude,
                    output ready);
endinterface

>>> hdl/prt_result_if.sv
// ----------------------------------------------------------------------------
// prt_result_if: result channel
// Valid/ready channel carrying the status, verdict and report of one item.
// ----------------------------------------------------------------------------
interface prt_result_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [prt_pkg::VERDICT_W-1:0]   verdict;
    logic [prt_pkg::COUNT_W-1:0]     compared_count;
    logic [prt_pkg::COUNT_W-1:0]     matched_count;
    logic [prt_pkg::COUNT_W-1:0]     corrected_count;
    logic [prt_pkg::COUNT_W-1:0]     resync_count;
    logic [prt_pkg::COUNT_W-1:0]     unpredicted_count;
    logic [prt_pkg::TICK_W-1:0]      last_corrected;
    logic [prt_pkg::MAG_W-1:0]       peak_error;

    modport source (output valid, status, verdict, compared_count, matched_count,
                           corrected_count, resync_count, unpredicted_count,
                           last_corrected, peak_error,
                    input ready);
    modport sink   (input valid, status, verdict, compared_count, matched_count,
                          corrected_count, resync_count, unpredicted_count,
                          last_corrected, peak_error,
                    output ready);
endinterface

>>> hdl/prt_cfg_if.sv
// ----------------------------------------------------------------------------
// prt_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface prt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [prt_pkg::CFG_INDEX_W-1:0]   index;
    logic [prt_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/prt_cell.sv
// ----------------------------------------------------------------------------
// prt_cell: one table entry
// Holds one (tick, hash) pair with its valid bit, matches it against the
// broadcast tick and forwards the hit hash and free flag to its neighbor.
// ----------------------------------------------------------------------------
module prt_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  prt_pkg::prt_cmd_t  cmd,
    input  prt_pkg::prt_link_t link_in,
    output prt_pkg::prt_link_t link_out
);
    import prt_pkg::*;

    logic [TICK_W-1:0] tick_reg;
    logic [HASH_W-1:0] hash_reg;
    logic              valid_reg;
    logic              hit_reg;
    logic              claim_reg;

    logic              hit;
    logic              free;
    logic              below_floor;
    logic              new_below_floor;

    assign hit             = valid_reg && (tick_reg == cmd.tick);
    assign free            = !valid_reg;
    assign below_floor     = tick_reg < cmd.floor_tick;
    assign new_below_floor = cmd.tick < cmd.floor_tick;

    // Valid ticks are unique, so at most one cell hits and the OR chain
    // delivers that cell's hash. The lowest free cell claims the insert.
    assign link_out.found     = link_in.found | hit;
    assign link_out.hash      = link_in.hash | (hit ? hash_reg : {HASH_W{1'b0}});
    assign link_out.free_seen = link_in.free_seen | free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            claim_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                hit_reg   <= hit;
                claim_reg <= free && !link_in.free_seen;
            end
            case (cmd.op)
                OP_INSERT:
                begin
                    if (claim_reg)
                        valid_reg <= !new_below_floor;
                    else if (valid_reg && below_floor)
                        valid_reg <= 1'b0;
                end
                OP_CLEAR:
                    valid_reg <= 1'b0;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_INSERT:
            begin
                if (claim_reg)
                begin
                    tick_reg <= cmd.tick;
                    hash_reg <= cmd.hash;
                end
            end
            OP_OVERWRITE:
            begin
                if (hit_reg)
                    hash_reg <= cmd.hash;
            end
            default:
                ;
        endcase
    end

endmodule

>>> hdl/prediction_reconcile_table_core.sv
// ----------------------------------------------------------------------------
// prediction_reconcile_table_core: windowed prediction table with reconcile
// Stores predicted (tick, hash) pairs in a row of cells, evicts entries that
// fall behind the window and grades authoritative hashes against them.
//
//   Channel  Dir  Handshake      Payload
//   items    in   valid/ready    mode, tick_number, hash_value, error_magnitude
//   results  out  valid/ready    status, verdict, five counters, last/peak
//   cfg      in   valid/ready    index, data (0 window_length, 1 error_tolerance)
//
// Each item passes through a match state, in which every cell compares its
// tick against the item, and then an update state that writes the cell row and
// the report. A new item is taken in the update cycle of the previous one.
// Reset empties the table at once; there is no clearing pass.
// A result not yet taken holds the next item in its update cycle.
// ----------------------------------------------------------------------------
module prediction_reconcile_table_core
#(
    parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    prt_item_if.sink     items,
    prt_result_if.source results,
    prt_cfg_if.sink      cfg
);
    import prt_pkg::*;

    prt_state_t state_reg, state_next;

    logic [MODE_W-1:0]  mode_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [MAG_W-1:0]   mag_reg;

    logic               found_reg;
    logic [HASH_W-1:0]  hit_hash_reg;
    logic               has_free_reg;
    logic [TICK_W-1:0]  floor_reg;

    logic [TICK_W-1:0]  newest_reg, newest_next;
    logic [COUNT_W-1:0] compared_reg, compared_next;
    logic [COUNT_W-1:0] matched_reg, matched_next;
    logic [COUNT_W-1:0] corrected_reg, corrected_next;
    logic [COUNT_W-1:0] resync_reg, resync_next;
    logic [COUNT_W-1:0] unpredicted_reg, unpredicted_next;
    logic [TICK_W-1:0]  last_corrected_reg, last_corrected_next;
    logic [MAG_W-1:0]   peak_error_reg, peak_error_next;

    logic [WINDOW_W-1:0] window_reg;
    logic [MAG_W-1:0]    tolerance_reg;

    logic                status_reg, status_next;
    logic [VERDICT_W-1:0] verdict_reg, verdict_next;
    logic                out_valid_reg;

    logic                out_free;
    logic                item_accept;
    logic                do_update;
    logic [TICK_W-1:0]   newest_max;
    logic [TICK_W-1:0]   window_ext;
    logic [TICK_W-1:0]   floor_calc;

    prt_cmd_t            cmd;
    prt_link_t           link [TABLE_ENTRIES+1];

    // ---------------------------------------------------------------- cells
    assign link[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        prt_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (link[g]),
            .link_out (link[g+1])
        );
    end

    // ---------------------------------------------------------------- control
    assign out_free    = !out_valid_reg || results.ready;
    assign item_accept = items.valid && items.ready;

    always_comb
    begin
        state_next  = state_reg;
        items.ready = 1'b0;
        do_update   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    do_update   = 1'b1;
                    items.ready = 1'b1;
                    state_next  = items.valid ? ST_MATCH : ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A predict raises the newest tick before the window floor is taken.
    assign newest_max = (mode_reg == MODE_PREDICT && tick_reg > newest_reg)
                        ? tick_reg : newest_reg;
    assign window_ext = {{(TICK_W-WINDOW_W){1'b0}}, window_reg};
    assign floor_calc = (newest_max > window_ext) ? newest_max - window_ext
                                                  : {TICK_W{1'b0}};

    always_comb
    begin
        cmd.latch      = (state_reg == ST_MATCH);
        cmd.tick       = tick_reg;
        cmd.hash       = hash_reg;
        cmd.floor_tick = floor_reg;
        cmd.op         = OP_NONE;
        if (do_update)
        begin
            if (mode_reg == MODE_PREDICT)
            begin
                if (found_reg)
                    cmd.op = OP_OVERWRITE;
                else if (has_free_reg)
                    cmd.op = OP_INSERT;
            end
            else if (mode_reg == MODE_CLEAR)
                cmd.op = OP_CLEAR;
        end
    end

    // ---------------------------------------------------------------- report
    always_comb
    begin
        status_next         = 1'b0;
        verdict_next        = VERDICT_MATCHED;
        newest_next         = newest_reg;
        compared_next       = compared_reg;
        matched_next        = matched_reg;
        corrected_next      = corrected_reg;
        resync_next         = resync_reg;
        unpredicted_next    = unpredicted_reg;
        last_corrected_next = last_corrected_reg;
        peak_error_next     = peak_error_reg;
        case (mode_reg)
            MODE_PREDICT:
            begin
                newest_next = newest_max;
                status_next = !found_reg && !has_free_reg;
            end
            MODE_COMPARE:
            begin
                compared_next = sat_inc(compared_reg);
                if (newest_reg != {TICK_W{1'b0}} && tick_reg < floor_reg)
                begin
                    verdict_next = VERDICT_RESYNC;
                    resync_next  = sat_inc(resync_reg);
                end
                else if (!found_reg)
                begin
                    verdict_next     = VERDICT_UNPREDICTED;
                    unpredicted_next = sat_inc(unpredicted_reg);
                end
                else if (hit_hash_reg == hash_reg || mag_reg <= tolerance_reg)
                begin
                    verdict_next = VERDICT_MATCHED;
                    matched_next = sat_inc(matched_reg);
                end
                else
                begin
                    verdict_next        = VERDICT_CORRECT;
                    corrected_next      = sat_inc(corrected_reg);
                    last_corrected_next = tick_reg;
                    if (mag_reg > peak_error_reg)
                        peak_error_next = mag_reg;
                end
            end
            MODE_CLEAR:
            begin
                newest_next         = {TICK_W{1'b0}};
                compared_next       = {COUNT_W{1'b0}};
                matched_next        = {COUNT_W{1'b0}};
                corrected_next      = {COUNT_W{1'b0}};
                resync_next         = {COUNT_W{1'b0}};
                unpredicted_next    = {COUNT_W{1'b0}};
                last_corrected_next = {TICK_W{1'b0}};
                peak_error_next     = {MAG_W{1'b0}};
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg         <= {TICK_W{1'b0}};
            compared_reg       <= {COUNT_W{1'b0}};
            matched_reg        <= {COUNT_W{1'b0}};
            corrected_reg      <= {COUNT_W{1'b0}};
            resync_reg         <= {COUNT_W{1'b0}};
            unpredicted_reg    <= {COUNT_W{1'b0}};
            last_corrected_reg <= {TICK_W{1'b0}};
            peak_error_reg     <= {MAG_W{1'b0}};
            out_valid_reg      <= 1'b0;
            window_reg         <= WINDOW_RESET;
            tolerance_reg      <= TOLERANCE_RESET;
        end
        else
        begin
            if (do_update)
            begin
                newest_reg         <= newest_next;
                compared_reg       <= compared_next;
                matched_reg        <= matched_next;
                corrected_reg      <= corrected_next;
                resync_reg         <= resync_next;
                unpredicted_reg    <= unpredicted_next;
                last_corrected_reg <= last_corrected_next;
                peak_error_reg     <= peak_error_next;
                out_valid_reg      <= 1'b1;
            end
            else if (results.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_WINDOW:    window_reg    <= cfg.data[WINDOW_W-1:0];
                    CFG_TOLERANCE: tolerance_reg <= cfg.data[MAG_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // Item, match and result payload registers.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            mode_reg <= items.mode;
            tick_reg <= items.tick_number;
            hash_reg <= items.hash_value;
            mag_reg  <= items.error_magnitude;
        end
        if (state_reg == ST_MATCH)
        begin
            found_reg    <= link[TABLE_ENTRIES].found;
            hit_hash_reg <= link[TABLE_ENTRIES].hash;
            has_free_reg <= link[TABLE_ENTRIES].free_seen;
            floor_reg    <= floor_calc;
        end
        if (do_update)
        begin
            status_reg  <= status_next;
            verdict_reg <= verdict_next;
        end
    end

    assign cfg.ready = 1'b1;

    // The report registers change only when a new result is loaded, so they
    // always belong to the result on the channel.
    assign results.valid             = out_valid_reg;
    assign results.status            = status_reg;
    assign results.verdict           = verdict_reg;
    assign results.compared_count    = compared_reg;
    assign results.matched_count     = matched_reg;
    assign results.corrected_count   = corrected_reg;
    assign results.resync_count      = resync_reg;
    assign results.unpredicted_count = unpredicted_reg;
    assign results.last_corrected    = last_corrected_reg;
    assign results.peak_error        = peak_error_reg;

endmodule
